// ===== rtl/skbl_pkg.sv =====
// Shared types and constants for the skyline bottom-left placer.
// No dependencies; imported by every module of the block.
`default_nettype none
package skbl_pkg;

  localparam int unsigned MaxSeg = 256;
  localparam int unsigned IdxW   = $clog2(MaxSeg);
  localparam int unsigned CntW   = IdxW + 1;
  localparam int unsigned HW     = 32;
  localparam int unsigned XW     = 16;

  localparam logic [1:0] StPlaced = 2'd0;
  localparam logic [1:0] StWide   = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  // write port of the skyline store
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [XW-1:0]   left;
    logic [HW-1:0]   height;
  } mem_wr_t;

  // one finished placement
  typedef struct packed {
    logic [XW-1:0] id;
    logic [XW-1:0] px;
    logic [HW-1:0] py;
    logic [HW-1:0] total;
    logic [1:0]    status;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/skyline_bottom_left_placer.sv =====
// A rejected rectangle goes straight to the result; a placed one first scans the skyline,
// reading one segment at a time through the store's single read port.
// Throughput: one rectangle at a time; the next beat is taken once the result is registered.
// Reset: asynchronous, active low; empties the skyline to one segment, zero total height,
// strip width 65535. Entry 0 is written with the first rectangle, so no clearing pass.
// Depends on skbl_pkg, skbl_store and skbl_ctrl.
`default_nettype none
module skyline_bottom_left_placer import skbl_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [XW-1:0]   cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            first_of_run_i,
  input  wire logic [XW-1:0]   rect_id_i,
  input  wire logic [XW-1:0]   rect_width_i,
  input  wire logic [XW-1:0]   rect_height_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic      [XW-1:0]   placed_id_o,
  output logic      [XW-1:0]   pos_x_o,
  output logic      [HW-1:0]   pos_y_o,
  output logic      [HW-1:0]   packing_height_o,
  output logic      [1:0]      status_o
);

  logic [XW-1:0]   strip_q;
  logic            ready, res_valid, res_take;
  result_t         res, out_q;
  logic [IdxW-1:0] rd_addr;
  logic [XW-1:0]   rd_left;
  logic [HW-1:0]   rd_height;
  mem_wr_t         wr;
  logic            out_valid_q;

  // strip width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strip_q <= '1;
    else if (cfg_we_i) strip_q <= cfg_wdata_i;
  end

  assign in_stall_o = ~ready;
  assign res_take   = res_valid && (!out_valid_q || !out_stall_i);

  skbl_store u_store (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .rd_left_o   (rd_left),
    .rd_height_o (rd_height),
    .wr_i        (wr)
  );

  skbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .strip_i     (strip_q),
    .start_i     (in_valid_i && ready),
    .first_i     (first_of_run_i),
    .id_i        (rect_id_i),
    .rw_i        (rect_width_i),
    .rh_i        (rect_height_i),
    .ready_o     (ready),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .rd_left_i   (rd_left),
    .rd_height_i (rd_height),
    .wr_o        (wr)
  );

  // output register: hold while stalled, load a finished result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (res_take) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= res;
  end

  assign out_valid_o      = out_valid_q;
  assign placed_id_o      = out_q.id;
  assign pos_x_o          = out_q.px;
  assign pos_y_o          = out_q.py;
  assign packing_height_o = out_q.total;
  assign status_o         = out_q.status;

endmodule
`default_nettype wire

// ===== rtl/skbl_store.sv =====
// Skyline segment store: left edges and heights, one read and one write a cycle.
// Depends on skbl_pkg.
`default_nettype none
module skbl_store import skbl_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output logic      [XW-1:0]   rd_left_o,
  output logic      [HW-1:0]   rd_height_o,
  input  wire mem_wr_t         wr_i
);

  logic [XW-1:0] left_mem   [MaxSeg];
  logic [HW-1:0] height_mem [MaxSeg];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      left_mem[wr_i.addr]   <= wr_i.left;
      height_mem[wr_i.addr] <= wr_i.height;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_left_o   <= left_mem[rd_addr_i];
    rd_height_o <= height_mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/skbl_ctrl.sv =====
// Placement sequencer: window scan, cut search, table shift in either direction and top insert.
// Depends on skbl_pkg; drives the ports of skbl_store.
`default_nettype none
module skbl_ctrl import skbl_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [XW-1:0]   strip_i,
  input  wire logic            start_i,
  input  wire logic            first_i,
  input  wire logic [XW-1:0]   id_i,
  input  wire logic [XW-1:0]   rw_i,
  input  wire logic [XW-1:0]   rh_i,
  output logic                 ready_o,
  output logic                 res_valid_o,
  input  wire logic            res_take_i,
  output result_t              res_o,
  output logic      [IdxW-1:0] rd_addr_o,
  input  wire logic [XW-1:0]   rd_left_i,
  input  wire logic [HW-1:0]   rd_height_i,
  output mem_wr_t              wr_o
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_IRD  = 14'b00000000000010,
    S_IWT  = 14'b00000000000100,
    S_JRD  = 14'b00000000001000,
    S_JWT  = 14'b00000000010000,
    S_WEND = 14'b00000000100000,
    S_PICK = 14'b00000001000000,
    S_KRD  = 14'b00000010000000,
    S_KWT  = 14'b00000100000000,
    S_CHK  = 14'b00001000000000,
    S_CRD  = 14'b00010000000000,
    S_CWT  = 14'b00100000000000,
    S_WTOP = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, k_q, k_d, best_q, best_d;
  logic [CntW-1:0] src_q, src_d, dst_q, dst_d, newcnt_q, newcnt_d;
  logic [HW-1:0]   total_q, total_d, mx_q, mx_d, best_h_q, best_h_d, top_q, top_d;
  logic [XW-1:0]   left_i_q, left_i_d, best_left_q, best_left_d;
  logic [XW:0]     lim_q, lim_d, end_q, end_d;
  logic            found_q, found_d, desc_q, desc_d, fresh_q, fresh_d;
  logic [XW-1:0]   rw_q, rw_d, rh_q, rh_d;
  result_t         res_q, res_d;

  logic [XW:0]     lim_now, end1;
  logic [HW:0]     top_sum;
  logic [HW-1:0]   mx_new;
  logic [CntW:0]   newcnt_w;
  logic            src_last;

  assign lim_now  = {1'b0, rd_left_i} + {1'b0, rw_q};
  assign end1     = end_q + (XW+1)'(1);
  assign top_sum  = {1'b0, best_h_q} + (HW+1)'(rh_q);
  assign mx_new   = (rd_height_i > mx_q) ? rd_height_i : mx_q;
  assign newcnt_w = (CntW+1)'(best_q) + (CntW+1)'(1) + (CntW+1)'(cnt_q) - (CntW+1)'(k_q);
  assign src_last = desc_q ? (src_q == k_q) : (src_q + CntW'(1) == cnt_q);

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    best_d      = best_q;
    src_d       = src_q;
    dst_d       = dst_q;
    newcnt_d    = newcnt_q;
    total_d     = total_q;
    mx_d        = mx_q;
    best_h_d    = best_h_q;
    top_d       = top_q;
    left_i_d    = left_i_q;
    best_left_d = best_left_q;
    lim_d       = lim_q;
    end_d       = end_q;
    found_d     = found_q;
    desc_d      = desc_q;
    fresh_d     = fresh_q;
    rw_d        = rw_q;
    rh_d        = rh_q;
    res_d       = res_q;
    rd_addr_o   = i_q[IdxW-1:0];
    wr_o        = '0;

    case (state_q)
      // take a rectangle, clear the skyline if asked or if entry 0 is still unwritten; reject a zero or too-wide width
      S_IDLE: begin
        if (start_i) begin
          rw_d    = rw_i;
          rh_d    = rh_i;
          i_d     = '0;
          found_d = 1'b0;
          fresh_d = 1'b0;
          if (first_i || fresh_q) begin
            cnt_d   = CntW'(1);
            total_d = '0;
            wr_o.we = 1'b1;
          end
          res_d.id     = id_i;
          res_d.px     = '0;
          res_d.py     = '0;
          res_d.total  = first_i ? '0 : total_q;
          res_d.status = StWide;
          if (rw_i == '0 || rw_i > strip_i) state_d = S_DONE;
          else state_d = S_IRD;
        end
      end
      S_IRD: begin
        rd_addr_o = i_q[IdxW-1:0];
        state_d   = S_IWT;
      end
      // window start: stop the scan once the window runs past the strip, skip a start that cannot beat the best
      S_IWT: begin
        left_i_d = rd_left_i;
        lim_d    = lim_now;
        mx_d     = rd_height_i;
        j_d      = i_q + CntW'(1);
        if (lim_now > {1'b0, strip_i}) state_d = S_PICK;
        else if (found_q && rd_height_i >= best_h_q) begin
          i_d     = i_q + CntW'(1);
          state_d = (i_q + CntW'(1) == cnt_q) ? S_PICK : S_IRD;
        end else state_d = S_JRD;
      end
      S_JRD: begin
        rd_addr_o = j_q[IdxW-1:0];
        state_d   = (j_q == cnt_q) ? S_WEND : S_JWT;
      end
      // extend the window while segments start under the rectangle, dropping it once it cannot beat the best
      S_JWT: begin
        if ({1'b0, rd_left_i} >= lim_q) state_d = S_WEND;
        else begin
          mx_d = mx_new;
          j_d  = j_q + CntW'(1);
          if (found_q && mx_new >= best_h_q) begin
            i_d     = i_q + CntW'(1);
            state_d = (i_q + CntW'(1) == cnt_q) ? S_PICK : S_IRD;
          end else state_d = S_JRD;
        end
      end
      // keep the leftmost lowest peak
      S_WEND: begin
        if (!found_q || mx_q < best_h_q) begin
          found_d     = 1'b1;
          best_d      = i_q;
          best_h_d    = mx_q;
          best_left_d = left_i_q;
        end
        i_d     = i_q + CntW'(1);
        state_d = (i_q + CntW'(1) == cnt_q) ? S_PICK : S_IRD;
      end
      S_PICK: begin
        if (!found_q) state_d = S_DONE;
        else begin
          end_d   = {1'b0, best_left_q} + {1'b0, rw_q} - (XW+1)'(1);
          top_d   = top_sum[HW] ? '1 : top_sum[HW-1:0];
          k_d     = best_q;
          state_d = S_KRD;
        end
      end
      // find the first segment that reaches beyond the rectangle
      S_KRD: begin
        rd_addr_o = IdxW'(k_q + CntW'(1));
        if (k_q + CntW'(1) < cnt_q) state_d = S_KWT;
        else begin
          if ({1'b0, strip_i} <= end1) k_d = k_q + CntW'(1);
          state_d = S_CHK;
        end
      end
      S_KWT: begin
        if ({1'b0, rd_left_i} <= end1) begin
          k_d     = k_q + CntW'(1);
          state_d = S_KRD;
        end else state_d = S_CHK;
      end
      // check room, then set up the move direction
      S_CHK: begin
        newcnt_d = newcnt_w[CntW-1:0];
        if (newcnt_w > (CntW+1)'(MaxSeg)) begin
          res_d.status = StFull;
          state_d      = S_DONE;
        end else if (k_q == cnt_q) state_d = S_WTOP;
        else if (k_q == best_q) begin
          desc_d  = 1'b1;
          src_d   = cnt_q - CntW'(1);
          dst_d   = cnt_q;
          state_d = S_CRD;
        end else begin
          desc_d  = 1'b0;
          src_d   = k_q;
          dst_d   = best_q + CntW'(1);
          state_d = S_CRD;
        end
      end
      S_CRD: begin
        rd_addr_o = src_q[IdxW-1:0];
        state_d   = S_CWT;
      end
      // move one segment, trimming the partly covered one
      S_CWT: begin
        wr_o.we     = 1'b1;
        wr_o.addr   = dst_q[IdxW-1:0];
        wr_o.height = rd_height_i;
        wr_o.left   = (src_q == k_q && {1'b0, rd_left_i} <= end_q) ?
                      end1[XW-1:0] : rd_left_i;
        if (src_last) state_d = S_WTOP;
        else begin
          state_d = S_CRD;
          src_d   = desc_q ? src_q - CntW'(1) : src_q + CntW'(1);
          dst_d   = desc_q ? dst_q - CntW'(1) : dst_q + CntW'(1);
        end
      end
      // insert the new top segment
      S_WTOP: begin
        wr_o.we      = 1'b1;
        wr_o.addr    = best_q[IdxW-1:0];
        wr_o.left    = best_left_q;
        wr_o.height  = top_q;
        cnt_d        = newcnt_q;
        total_d      = (top_q > total_q) ? top_q : total_q;
        res_d.px     = best_left_q;
        res_d.py     = best_h_q;
        res_d.total  = (top_q > total_q) ? top_q : total_q;
        res_d.status = StPlaced;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CntW'(1);
      total_q <= '0;
      found_q <= 1'b0;
      desc_q  <= 1'b0;
      fresh_q <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      found_q <= found_d;
      desc_q  <= desc_d;
      fresh_q <= fresh_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    best_q      <= best_d;
    src_q       <= src_d;
    dst_q       <= dst_d;
    newcnt_q    <= newcnt_d;
    mx_q        <= mx_d;
    best_h_q    <= best_h_d;
    top_q       <= top_d;
    left_i_q    <= left_i_d;
    best_left_q <= best_left_d;
    lim_q       <= lim_d;
    end_q       <= end_d;
    rw_q        <= rw_d;
    rh_q        <= rh_d;
    res_q       <= res_d;
  end

endmodule
`default_nettype wire

// ===== rtl/skbl_checker.sv =====
// Port-level checks for the skyline placer, bound to the top level.
// Depends on skbl_pkg and skyline_bottom_left_placer.
`default_nettype none
module skbl_checker import skbl_pkg::*; (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire logic [XW-1:0] pos_x_o,
  input wire logic [HW-1:0] pos_y_o,
  input wire logic [1:0]    status_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(pos_y_o))
    else $error("stalled result beat changed");

  // a rejected rectangle reports the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StPlaced |-> pos_x_o == '0 && pos_y_o == '0)
    else $error("rejected rectangle with non-zero position");

  // only the three defined status codes appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == StPlaced || status_o == StWide || status_o == StFull)
    else $error("undefined status code");

  // no result during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind skyline_bottom_left_placer skbl_checker u_skbl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o),
  .status_o    (status_o)
);
`default_nettype wire
